[hdl/wtw_pkg.sv]
// ----------------------------------------------------------------------------
// wtw_pkg
// Shared types, codes and constants of the worm trail walker: item layouts,
// item modes, register indexes, reset values and the direction table.
// ----------------------------------------------------------------------------
package wtw_pkg;

    // Defaults for the top-level parameters
    localparam int WORM_COUNT_DEF = 64;
    localparam int MAX_TRAIL_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths
    localparam int MODE_BITS      = 2;
    localparam int WORM_IDX_BITS  = 6;
    localparam int HEAD_BITS      = 6;
    localparam int COORD_OUT_BITS = 12;
    localparam int FRAME_BITS     = 12;
    localparam int TRAIL_LEN_BITS = 7;
    localparam int COLOR_CNT_BITS = 7;
    localparam int COLOR_OUT_BITS = 6;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 12;

    // Headings, 10 degrees apart
    localparam int DIR_COUNT = 36;
    localparam logic [HEAD_BITS-1:0] DIR_LAST = HEAD_BITS'(DIR_COUNT - 1);

    // Colour count ceiling
    localparam logic [COLOR_CNT_BITS-1:0] COLOR_MAX = 7'd64;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRAIL_LENGTH = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_COUNT  = 2'd3;

    // Register reset values
    localparam logic [FRAME_BITS-1:0]     FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FRAME_BITS-1:0]     FRAME_HEIGHT_RST = 12'd480;
    localparam logic [TRAIL_LEN_BITS-1:0] TRAIL_LENGTH_RST = 7'd50;
    localparam logic [COLOR_CNT_BITS-1:0] COLOR_COUNT_RST  = 7'd64;

    // Item modes
    typedef enum logic [MODE_BITS-1:0] {
        MODE_INIT  = 2'd0,
        MODE_STEP  = 2'd1,
        MODE_FRAME = 2'd2,
        MODE_NOP   = 2'd3
    } t_wtw_mode;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOKUP,
        ST_MOD
    } t_wtw_state;

    // Input item
    typedef struct packed {
        logic [MODE_BITS-1:0]     mode;
        logic [WORM_IDX_BITS-1:0] worm_index;
        logic                     turn;
        logic [HEAD_BITS-1:0]     start_heading;
    } t_wtw_in;

    // Result item
    typedef struct packed {
        logic [COORD_OUT_BITS-1:0] erase_x;
        logic [COORD_OUT_BITS-1:0] erase_y;
        logic [COORD_OUT_BITS-1:0] draw_x;
        logic [COORD_OUT_BITS-1:0] draw_y;
        logic [COLOR_OUT_BITS-1:0] color_index;
    } t_wtw_out;

    // Rounded 2*cos and 2*sin per heading
    localparam logic signed [2:0] DIR_DX [DIR_COUNT] = '{
        3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd1, 3'sd1, 3'sd1, 3'sd0,
        3'sd0, 3'sd0, -3'sd1, -3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd2, -3'sd2,
        -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd1, -3'sd1, -3'sd1, 3'sd0,
        3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd2, 3'sd2
    };
    localparam logic signed [2:0] DIR_DY [DIR_COUNT] = '{
        3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd2, 3'sd2,
        3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd1, 3'sd1, 3'sd1, 3'sd0,
        3'sd0, 3'sd0, -3'sd1, -3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd2, -3'sd2,
        -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd1, -3'sd1, -3'sd1, 3'sd0
    };

endpackage

[hdl/wtw_ram.sv]
// ----------------------------------------------------------------------------
// wtw_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module wtw_ram #(
    parameter int AW = 12,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/wtw_rem_unit.sv]
// ----------------------------------------------------------------------------
// wtw_rem_unit
// Restoring remainder unit: one dividend bit per cycle, all N bits per
// operation. Result held until the next start.
// ----------------------------------------------------------------------------
module wtw_rem_unit #(
    parameter int N = 14,
    parameter int D = 13
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_busy,
    output logic [D-1:0] o_rem
);

    localparam int CW = $clog2(N + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_dvd;
    logic [D-1:0]  r_div;
    logic [D-1:0]  r_rem;
    logic [D:0]    trial;
    logic [D-1:0]  n_rem;

    // shift in next dividend bit, subtract where it fits
    always_comb begin
        trial = {r_rem, r_dvd[N-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = D'(trial - {1'b0, r_div});
        end else begin
            n_rem = D'(trial);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(N);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

    // partial remainder stays below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("remainder reached divisor");

    // a start runs the full bit count
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_cnt == CW'(N)))
        else $error("start did not load the counter");

    // last bit ends the operation
    a_last_bit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CW'(1) && !i_start) |=> !r_busy)
        else $error("unit still busy after the last bit");

endmodule

[hdl/worm_trail_walker_unit.sv]
// ----------------------------------------------------------------------------
// worm_trail_walker_unit
// Random-walk worms on a wrapping screen. Per-worm state and trail rings live
// in two synchronous RAMs; a controller reads, updates and writes them back.
// ----------------------------------------------------------------------------
// Step item: accepted in idle, result loaded once the bit-serial wrap units
//   finish and the output is free; the next item is taken the cycle after.
// Init item: one ring entry written per cycle until the clamped trail_length are in.
// End-of-frame and ignored items: handled in idle; a waiting result never blocks.
// Reset: registers to defaults, colour phase to 0; RAMs are not cleared.
// ----------------------------------------------------------------------------
module worm_trail_walker_unit import wtw_pkg::*; #(
    parameter int WORM_COUNT = WORM_COUNT_DEF,
    parameter int MAX_TRAIL  = MAX_TRAIL_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_wtw_in                  i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_wtw_out                 o_out_item,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int SZW   = CB + 1;
    localparam int XW    = CB + 2;
    localparam int EXT_W = ((CB > FRAME_BITS) ? CB : FRAME_BITS) + 1;
    localparam int WW    = (WORM_COUNT > 1) ? $clog2(WORM_COUNT) : 1;
    localparam int TB    = $clog2(MAX_TRAIL);
    localparam int TLW   = $clog2(MAX_TRAIL + 1);
    localparam int TAW   = WW + TB;
    localparam int SW    = 2 * CB + HEAD_BITS + TB;
    localparam int CSW   = COLOR_CNT_BITS;

    // configuration registers
    logic [FRAME_BITS-1:0]     r_frame_width;
    logic [FRAME_BITS-1:0]     r_frame_height;
    logic [TRAIL_LEN_BITS-1:0] r_trail_length;
    logic [COLOR_CNT_BITS-1:0] r_color_count;

    // control and item registers
    t_wtw_state                r_state, n_state;
    logic [COLOR_OUT_BITS-1:0] r_phase, n_phase;
    logic [WW-1:0]             r_worm;
    logic [WORM_IDX_BITS-1:0]  r_widx;
    logic                      r_turn;
    logic [HEAD_BITS-1:0]      r_head0;
    logic [TB-1:0]             r_slot;
    logic [TB-1:0]             r_tp_new;
    logic [HEAD_BITS-1:0]      r_hd_new;
    logic                      r_out_valid;
    t_wtw_out                  r_out_item;

    // clamped sizes
    logic [EXT_W-1:0] fw_ext, fh_ext, size_lim;
    logic [SZW-1:0]   wid, hei;
    logic [TLW-1:0]   tl;
    logic [CSW-1:0]   cc;
    logic [CB-1:0]    cx, cy;

    // item decode
    logic                 acc;
    logic                 worm_ok;
    t_wtw_mode            in_mode;
    logic [HEAD_BITS-1:0] sh_mod;

    // step lookup
    logic [CB-1:0]        hx, hy;
    logic [HEAD_BITS-1:0] hd, nd;
    logic [TB-1:0]        tp, t_new;
    logic [TLW-1:0]       t_ext;
    logic [XW-1:0]        x_dvd, y_dvd;
    logic [CSW-1:0]       c_dvd;

    // memory ports
    logic            trail_we, trail_re;
    logic [TAW-1:0]  trail_waddr, trail_raddr;
    logic [2*CB-1:0] trail_wdata, trail_rdata;
    logic            worm_we, worm_re;
    logic [WW-1:0]   worm_waddr, worm_raddr;
    logic [SW-1:0]   worm_wdata, worm_rdata;

    // wrap units
    logic           rem_start;
    logic           x_busy, y_busy, c_busy;
    logic [SZW-1:0] x_rem, y_rem;
    logic [CSW-1:0] c_rem;
    logic           out_free, out_load;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_trail_length <= TRAIL_LENGTH_RST;
            r_color_count  <= COLOR_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_TRAIL_LENGTH: r_trail_length <= TRAIL_LEN_BITS'(i_cfg_data);
                CFG_COLOR_COUNT:  r_color_count  <= COLOR_CNT_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // clamp registers to their working ranges
    always_comb begin
        fw_ext   = EXT_W'(r_frame_width);
        fh_ext   = EXT_W'(r_frame_height);
        size_lim = EXT_W'(1) << CB;
        if (r_frame_width == '0) begin
            wid = SZW'(1);
        end else if (fw_ext > size_lim) begin
            wid = SZW'(size_lim);
        end else begin
            wid = SZW'(fw_ext);
        end
        if (r_frame_height == '0) begin
            hei = SZW'(1);
        end else if (fh_ext > size_lim) begin
            hei = SZW'(size_lim);
        end else begin
            hei = SZW'(fh_ext);
        end
        if (r_trail_length == '0) begin
            tl = TLW'(1);
        end else if (32'(r_trail_length) > MAX_TRAIL) begin
            tl = TLW'(MAX_TRAIL);
        end else begin
            tl = TLW'(r_trail_length);
        end
        if (r_color_count == '0) begin
            cc = CSW'(1);
        end else if (r_color_count > COLOR_MAX) begin
            cc = COLOR_MAX;
        end else begin
            cc = r_color_count;
        end
        cx = CB'(wid >> 1);
        cy = CB'(hei >> 1);
    end

    // input decode
    assign o_in_stall = (r_state != ST_IDLE);
    assign acc        = i_in_valid && !o_in_stall;
    assign in_mode    = t_wtw_mode'(i_in_item.mode);
    assign worm_ok    = 32'(i_in_item.worm_index) < WORM_COUNT;
    assign sh_mod     = (i_in_item.start_heading > DIR_LAST)
                      ? HEAD_BITS'(i_in_item.start_heading - HEAD_BITS'(DIR_COUNT))
                      : i_in_item.start_heading;

    // worm record fields: head x, head y, heading, tail pointer
    assign hx = worm_rdata[SW-1 -: CB];
    assign hy = worm_rdata[SW-1-CB -: CB];
    assign hd = worm_rdata[TB+HEAD_BITS-1 -: HEAD_BITS];
    assign tp = worm_rdata[TB-1:0];

    // tail advance, turn and move offsets
    always_comb begin
        t_ext = TLW'(tp) + TLW'(1);
        t_new = (t_ext >= tl) ? '0 : TB'(t_ext);
        if (r_turn) begin
            nd = (hd == DIR_LAST) ? '0 : hd + HEAD_BITS'(1);
        end else begin
            nd = (hd == '0) ? DIR_LAST : hd - HEAD_BITS'(1);
        end
        x_dvd = XW'(hx) + {wid, 1'b0} + XW'(DIR_DX[nd]);
        y_dvd = XW'(hy) + {hei, 1'b0} + XW'(DIR_DY[nd]);
        c_dvd = CSW'(r_widx) + CSW'(r_phase);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // next state, memory controls
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        trail_we    = 1'b0;
        trail_re    = 1'b0;
        trail_waddr = {r_worm, r_slot};
        trail_wdata = {cx, cy};
        trail_raddr = {r_worm, t_new};
        worm_we     = 1'b0;
        worm_re     = 1'b0;
        worm_waddr  = r_worm;
        worm_wdata  = {cx, cy, r_head0, TB'(0)};
        worm_raddr  = WW'(i_in_item.worm_index);
        rem_start   = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    unique case (in_mode)
                        MODE_INIT: begin
                            if (worm_ok) begin
                                n_state = ST_FILL;
                            end
                        end
                        MODE_STEP: begin
                            if (worm_ok) begin
                                worm_re = 1'b1;
                                n_state = ST_LOOKUP;
                            end
                        end
                        MODE_FRAME: begin
                            if ((CSW'(r_phase) + CSW'(1)) >= cc) begin
                                n_phase = '0;
                            end else begin
                                n_phase = r_phase + COLOR_OUT_BITS'(1);
                            end
                        end
                        MODE_NOP: ;
                    endcase
                end
            end
            ST_FILL: begin
                // ring entry per cycle, worm record alongside
                trail_we = 1'b1;
                worm_we  = 1'b1;
                if (TLW'(r_slot) == tl - TLW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOOKUP: begin
                trail_re  = 1'b1;
                rem_start = 1'b1;
                n_state   = ST_MOD;
            end
            ST_MOD: begin
                trail_waddr = {r_worm, r_tp_new};
                trail_wdata = {CB'(x_rem), CB'(y_rem)};
                worm_wdata  = {CB'(x_rem), CB'(y_rem), r_hd_new, r_tp_new};
                if (!x_busy && !y_busy && !c_busy && out_free) begin
                    trail_we = 1'b1;
                    worm_we  = 1'b1;
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and step registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_worm  <= WW'(i_in_item.worm_index);
            r_widx  <= i_in_item.worm_index;
            r_turn  <= i_in_item.turn;
            r_head0 <= sh_mod;
            r_slot  <= '0;
        end else if (r_state == ST_FILL) begin
            r_slot <= r_slot + TB'(1);
        end
        if (r_state == ST_LOOKUP) begin
            r_tp_new <= t_new;
            r_hd_new <= nd;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.erase_x     <= COORD_OUT_BITS'(trail_rdata[2*CB-1 -: CB]);
            r_out_item.erase_y     <= COORD_OUT_BITS'(trail_rdata[CB-1:0]);
            r_out_item.draw_x      <= COORD_OUT_BITS'(CB'(x_rem));
            r_out_item.draw_y      <= COORD_OUT_BITS'(CB'(y_rem));
            r_out_item.color_index <= COLOR_OUT_BITS'(c_rem);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // trail rings, one row of MAX_TRAIL slots per worm
    wtw_ram #(
        .AW (TAW),
        .DW (2 * CB)
    ) u_trail_ram (
        .i_clk   (i_clk),
        .i_we    (trail_we),
        .i_waddr (trail_waddr),
        .i_wdata (trail_wdata),
        .i_re    (trail_re),
        .i_raddr (trail_raddr),
        .o_rdata (trail_rdata)
    );

    // per-worm records
    wtw_ram #(
        .AW (WW),
        .DW (SW)
    ) u_worm_ram (
        .i_clk   (i_clk),
        .i_we    (worm_we),
        .i_waddr (worm_waddr),
        .i_wdata (worm_wdata),
        .i_re    (worm_re),
        .i_raddr (worm_raddr),
        .o_rdata (worm_rdata)
    );

    // x and y wrap, colour wrap
    wtw_rem_unit #(
        .N (XW),
        .D (SZW)
    ) u_x_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (x_dvd),
        .i_divisor  (wid),
        .o_busy     (x_busy),
        .o_rem      (x_rem)
    );

    wtw_rem_unit #(
        .N (XW),
        .D (SZW)
    ) u_y_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (y_dvd),
        .i_divisor  (hei),
        .o_busy     (y_busy),
        .o_rem      (y_rem)
    );

    wtw_rem_unit #(
        .N (CSW),
        .D (CSW)
    ) u_c_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (c_dvd),
        .i_divisor  (cc),
        .o_busy     (c_busy),
        .o_rem      (c_rem)
    );

    // a result only appears after the wrap phase
    a_result_from_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == ST_MOD))
        else $error("result loaded outside the wrap phase");

    // wrap units are free when a lookup starts them
    a_units_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP) |-> (!x_busy && !y_busy && !c_busy))
        else $error("wrap unit busy at lookup");

    // entering the wrap phase finds the units running
    a_units_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD && $past(r_state) == ST_LOOKUP) |-> (x_busy && y_busy))
        else $error("wrap units not started");

    // no RAM write while a step lookup reads
    a_no_write_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP) |-> (!trail_we && !worm_we))
        else $error("write during lookup");

endmodule
